// File: src/xmb_pkg.sv
// shared types, codes and constants of the xmodem block receiver
package xmb_pkg;

	localparam int BLOCK_BYTES_DEF = 128;

	localparam int OP_W    = 2;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 7;
	localparam int STAT_W  = 3;
	localparam int TICK_W  = 16;
	localparam int RETRY_W = 4;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	localparam logic [TICK_W-1:0]  FIRST_TIMEOUT_RST = TICK_W'(10000);
	localparam logic [TICK_W-1:0]  BLOCK_TIMEOUT_RST = TICK_W'(1000);
	localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = RETRY_W'(10);

	localparam logic [BYTE_W-1:0] C_SOH = 8'h01;
	localparam logic [BYTE_W-1:0] C_EOT = 8'h04;
	localparam logic [BYTE_W-1:0] C_ACK = 8'h06;
	localparam logic [BYTE_W-1:0] C_NAK = 8'h15;
	localparam logic [BYTE_W-1:0] C_CAN = 8'h18;

	typedef enum logic [OP_W-1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_READ  = 2'd2,
		OP_START = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_BUSY    = 3'd0,
		ST_ACCEPT  = 3'd1,
		ST_DONE    = 3'd2,
		ST_CANCEL  = 3'd3,
		ST_SYNC    = 3'd4,
		ST_TIMEOUT = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_FRAME = 2'd2
	} phase_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_FIRST_TIMEOUT = 2'd0,
		REG_BLOCK_TIMEOUT = 2'd1,
		REG_MAX_RETRIES   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0]  first_timeout;
		logic [TICK_W-1:0]  block_timeout;
		logic [RETRY_W-1:0] max_retries;
	} cfg_t;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		status_t           status;
		logic [BYTE_W-1:0] block_number;
		logic              read_op;
	} ctrl_res_t;

endpackage

// File: src/xmb_item_if.sv
// input channel carrying one event word
interface xmb_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] rx_byte;
	logic [6:0] read_index;

	modport source (output valid, output operation, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input operation, input rx_byte, input read_index,
		output ready);
endinterface

// File: src/xmb_result_if.sv
// output channel carrying one result word
interface xmb_result_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [2:0] status;
	logic [7:0] block_number;
	logic [7:0] read_data;

	modport source (output valid, output tx_valid, output tx_byte, output status,
		output block_number, output read_data, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input status,
		input block_number, input read_data, output ready);
endinterface

// File: src/xmb_ram.sv
// generic single-port-write ram with registered read
module xmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/xmb_ctrl.sv
// protocol state and reply decision for one event word
module xmb_ctrl import xmb_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  op_t                            op,
	input  logic [BYTE_W-1:0]              rx_byte,
	input  cfg_t                           cfg,
	output ctrl_res_t                      res,
	output logic                           wr_en,
	output logic [$clog2(BLOCK_BYTES)-1:0] wr_addr,
	output logic [BYTE_W-1:0]              wr_data
);

	localparam int AW    = $clog2(BLOCK_BYTES);
	localparam int POS_W = $clog2(BLOCK_BYTES + 4);
	localparam logic [POS_W-1:0] POS_DATA = POS_W'(3);
	localparam logic [POS_W-1:0] POS_SUM  = POS_W'(BLOCK_BYTES + 3);

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [TICK_W-1:0]   elapsed_q, elapsed_d;
	logic [RETRY_W-1:0]  retry_q, retry_d;
	logic [BYTE_W-1:0]   expected_q, expected_d;
	logic [BYTE_W-1:0]   header_q, header_d;
	logic [BYTE_W-1:0]   fblock_q, fblock_d;
	logic [BYTE_W-1:0]   finv_q, finv_d;
	logic [BYTE_W-1:0]   sum_q, sum_d;

	logic [TICK_W-1:0]   elapsed_inc;
	logic [TICK_W-1:0]   limit;
	logic [RETRY_W-1:0]  retry_inc;
	logic [BYTE_W-1:0]   prev_block;
	logic                do_nak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= '0;
			elapsed_q  <= '0;
			retry_q    <= '0;
			expected_q <= BYTE_W'(1);
			header_q   <= '0;
			fblock_q   <= '0;
			finv_q     <= '0;
			sum_q      <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			elapsed_q  <= elapsed_d;
			retry_q    <= retry_d;
			expected_q <= expected_d;
			header_q   <= header_d;
			fblock_q   <= fblock_d;
			finv_q     <= finv_d;
			sum_q      <= sum_d;
		end
	end

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);
	assign retry_inc   = (retry_q == '1) ? retry_q : retry_q + RETRY_W'(1);
	assign limit       = (phase_q == PH_WAIT) ? cfg.first_timeout : cfg.block_timeout;
	assign prev_block  = expected_q - BYTE_W'(1);
	assign wr_addr     = AW'(pos_q - POS_DATA);
	assign wr_data     = rx_byte;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		elapsed_d  = elapsed_q;
		retry_d    = retry_q;
		expected_d = expected_q;
		header_d   = header_q;
		fblock_d   = fblock_q;
		finv_d     = finv_q;
		sum_d      = sum_q;
		res        = '{tx_valid: 1'b0, tx_byte: '0, status: ST_BUSY,
			block_number: '0, read_op: 1'b0};
		wr_en      = 1'b0;
		do_nak     = 1'b0;

		case (op)
			OP_START: begin
				expected_d   = BYTE_W'(1);
				retry_d      = '0;
				elapsed_d    = '0;
				pos_d        = '0;
				phase_d      = PH_WAIT;
				res.tx_valid = 1'b1;
				res.tx_byte  = C_NAK;
			end
			OP_READ: begin
				res.read_op = 1'b1;
			end
			OP_TICK: begin
				if (phase_q == PH_WAIT || phase_q == PH_FRAME) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= limit) begin
						do_nak = 1'b1;
					end
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_WAIT) begin
					if (rx_byte == C_CAN) begin
						res.status = ST_CANCEL;
						phase_d    = PH_IDLE;
					end else if (rx_byte == C_EOT) begin
						res.tx_valid = 1'b1;
						res.tx_byte  = C_ACK;
						res.status   = ST_DONE;
						phase_d      = PH_IDLE;
					end else begin
						header_d  = rx_byte;
						pos_d     = POS_W'(1);
						sum_d     = '0;
						elapsed_d = '0;
						phase_d   = PH_FRAME;
					end
				end else if (phase_q == PH_FRAME) begin
					if (pos_q == POS_W'(1)) begin
						fblock_d = rx_byte;
						pos_d    = POS_W'(2);
					end else if (pos_q == POS_W'(2)) begin
						finv_d = rx_byte;
						pos_d  = POS_DATA;
					end else if (pos_q >= POS_DATA && pos_q < POS_SUM) begin
						wr_en = 1'b1;
						sum_d = sum_q + rx_byte;
						pos_d = pos_q + POS_W'(1);
					end else if (header_q != C_SOH || rx_byte != sum_q) begin
						do_nak = 1'b1;
					end else begin
						pos_d     = '0;
						elapsed_d = '0;
						res.tx_valid = 1'b1;
						if (fblock_q == expected_q && finv_q == ~expected_q) begin
							res.tx_byte      = C_ACK;
							res.status       = ST_ACCEPT;
							res.block_number = fblock_q;
							expected_d       = expected_q + BYTE_W'(1);
							retry_d          = '0;
							phase_d          = PH_WAIT;
						end else if (fblock_q == prev_block && finv_q == ~prev_block) begin
							res.tx_byte = C_ACK;
							retry_d     = '0;
							phase_d     = PH_WAIT;
						end else begin
							res.tx_byte = C_CAN;
							res.status  = ST_SYNC;
							phase_d     = PH_IDLE;
						end
					end
				end
			end
			default: begin
				res.tx_valid = 1'b0;
			end
		endcase

		if (do_nak) begin
			res.tx_valid = 1'b1;
			res.tx_byte  = C_NAK;
			retry_d      = retry_inc;
			elapsed_d    = '0;
			pos_d        = '0;
			if (retry_inc >= cfg.max_retries) begin
				res.status = ST_TIMEOUT;
				phase_d    = PH_IDLE;
			end else begin
				phase_d = PH_WAIT;
			end
		end
	end

endmodule

// File: src/xmodem_block_receiver.sv
// top level of the xmodem block receiver
//
// events enter on the item channel: a byte from the line, a millisecond
// tick, a read of the stored data block, or a start. every event gives
// exactly one word on the result channel: the reply byte to send back
// (ack, nak or can, with tx_valid), a status code, the number of a block
// just accepted and, for a read, the stored data byte.
// an event word is registered in the input register, decided
// combinationally and lands in the result register; one event is taken
// every cycle while the result register is empty or being taken. the data
// store is a 128-byte ram written as the frame streams in and read with
// its registered port, so a read sees every byte written by earlier
// events.
// while the result register is full and not taken, the input register
// still accepts one more word, then ready drops until the result drains.
// reset sets the idle phase, expected block 1 and the timeout and retry
// registers to their defaults; the store is not cleared. configuration
// writes are registered and are meant for an idle block.
module xmodem_block_receiver import xmb_pkg::*; #(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	xmb_item_if.sink           item,
	xmb_result_if.source       result
);

	localparam int AW = $clog2(BLOCK_BYTES);

	cfg_t              cfg_q;
	logic              valid_s1;
	op_t               op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              valid_s2;
	ctrl_res_t         res_s2;
	ctrl_res_t         res;
	logic              advance;
	logic              en;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic [BYTE_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_timeout <= FIRST_TIMEOUT_RST;
			cfg_q.block_timeout <= BLOCK_TIMEOUT_RST;
			cfg_q.max_retries   <= MAX_RETRIES_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FIRST_TIMEOUT: cfg_q.first_timeout <= cfg_data;
				REG_BLOCK_TIMEOUT: cfg_q.block_timeout <= cfg_data;
				REG_MAX_RETRIES:   cfg_q.max_retries   <= cfg_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance    = !valid_s2 || result.ready;
	assign en         = advance && valid_s1;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= op_t'(item.operation);
			byte_s1 <= item.rx_byte;
			idx_s1  <= item.read_index;
		end
		if (en) begin
			res_s2 <= res;
		end
	end

	xmb_ctrl #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	xmb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BLOCK_BYTES)
	) u_store (
		.clk   (clk),
		.we    (en && wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (en && op_s1 == OP_READ),
		.raddr (AW'(idx_s1)),
		.rdata (rd_data)
	);

	assign result.valid        = valid_s2;
	assign result.tx_valid     = res_s2.tx_valid;
	assign result.tx_byte      = res_s2.tx_byte;
	assign result.status       = res_s2.status;
	assign result.block_number = res_s2.block_number;
	assign result.read_data    = res_s2.read_op ? rd_data : '0;

	a_accept_acks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == ST_ACCEPT |-> res_s2.tx_valid && res_s2.tx_byte == C_ACK)
		else $error("accepted block without ack");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.tx_valid |-> res_s2.tx_byte == '0)
		else $error("reply byte set without tx_valid");

	a_block_num: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status != ST_ACCEPT |-> res_s2.block_number == '0)
		else $error("block number outside an accept");

	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.read_op |-> !res_s2.tx_valid && res_s2.status == ST_BUSY)
		else $error("read word changed protocol output");

endmodule

// File: bench/xmodem_block_receiver_tb.sv
// self-checking bench for the xmodem block receiver: frames, replies, timeouts and store reads
`timescale 1ns / 100ps

module xmodem_block_receiver_tb;
	import xmb_pkg::*;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		status_t           status;
		logic [BYTE_W-1:0] block_number;
		logic [BYTE_W-1:0] read_data;
	} reply_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] rx_byte;
		logic [IDX_W-1:0]  read_index;
		logic              pause;
		reply_t            reply;
	} line_event_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	xmb_item_if item_bus ();
	xmb_result_if res_bus ();

	xmodem_block_receiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_bus),
		.result    (res_bus)
	);

	always #5 clk = ~clk;

	// receiver shadow state
	cfg_t              cfg_now;
	phase_t            rx_phase;
	logic [7:0]        frame_pos;
	logic [TICK_W-1:0] tick_cnt;
	logic [3:0]        retry_cnt;
	logic [7:0]        expect_blk;
	logic [7:0]        hdr_byte;
	logic [7:0]        frame_blk;
	logic [7:0]        frame_inv;
	logic [7:0]        data_sum;
	logic [7:0]        blk_store [BLOCK_BYTES_DEF];
	logic [BLOCK_BYTES_DEF-1:0] stored;

	line_event_t pend_q [$];
	reply_t      reply_q [$];

	int unsigned n_generated = 0;
	int unsigned n_events = 0;
	int unsigned n_checked = 0;
	int unsigned n_blocks = 0;
	int unsigned n_timeouts = 0;
	int unsigned n_syncs = 0;
	int unsigned n_settings = 0;
	int unsigned errors = 0;
	int unsigned tx_idle_pct = 23;
	int unsigned rx_idle_pct = 74;
	int unsigned frame_tick_pct = 1;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	bit          pause_flag = 1'b0;
	reply_t      got;
	reply_t      want;

	function automatic void send_nak(inout reply_t r);
		r.tx_valid = 1'b1;
		r.tx_byte  = C_NAK;
		if (retry_cnt != 4'hF)
			retry_cnt++;
		tick_cnt  = '0;
		frame_pos = 8'd0;
		if (retry_cnt >= cfg_now.max_retries) begin
			r.status = ST_TIMEOUT;
			rx_phase = PH_IDLE;
		end else begin
			rx_phase = PH_WAIT;
		end
	endfunction

	function automatic reply_t step_receiver(op_t op, logic [7:0] b, logic [6:0] idx);
		reply_t            r;
		logic [TICK_W-1:0] lim;
		logic [7:0]        prev;
		r.tx_valid     = 1'b0;
		r.tx_byte      = 8'h00;
		r.status       = ST_BUSY;
		r.block_number = 8'h00;
		r.read_data    = 8'h00;
		prev = expect_blk - 8'd1;
		case (op)
		OP_START: begin
			expect_blk = 8'd1;
			retry_cnt  = 4'd0;
			tick_cnt   = '0;
			frame_pos  = 8'd0;
			rx_phase   = PH_WAIT;
			r.tx_valid = 1'b1;
			r.tx_byte  = C_NAK;
		end
		OP_READ: r.read_data = blk_store[idx];
		OP_TICK: begin
			if (rx_phase == PH_WAIT || rx_phase == PH_FRAME) begin
				lim = (rx_phase == PH_WAIT) ? cfg_now.first_timeout : cfg_now.block_timeout;
				if (tick_cnt != 16'hFFFF)
					tick_cnt++;
				if (tick_cnt >= lim)
					send_nak(r);
			end
		end
		default: begin
			if (rx_phase == PH_WAIT) begin
				if (b == C_CAN) begin
					r.status = ST_CANCEL;
					rx_phase = PH_IDLE;
				end else if (b == C_EOT) begin
					r.tx_valid = 1'b1;
					r.tx_byte  = C_ACK;
					r.status   = ST_DONE;
					rx_phase   = PH_IDLE;
				end else begin
					hdr_byte  = b;
					frame_pos = 8'd1;
					data_sum  = 8'h00;
					tick_cnt  = '0;
					rx_phase  = PH_FRAME;
				end
			end else if (rx_phase == PH_FRAME) begin
				if (frame_pos == 8'd1) begin
					frame_blk = b;
					frame_pos = 8'd2;
				end else if (frame_pos == 8'd2) begin
					frame_inv = b;
					frame_pos = 8'd3;
				end else if (frame_pos < 8'(3 + BLOCK_BYTES_DEF)) begin
					blk_store[7'(frame_pos - 8'd3)] = b;
					stored[7'(frame_pos - 8'd3)]    = 1'b1;
					data_sum  = data_sum + b;
					frame_pos = frame_pos + 8'd1;
				end else if (hdr_byte != C_SOH || b != data_sum) begin
					send_nak(r);
				end else begin
					frame_pos = 8'd0;
					tick_cnt  = '0;
					r.tx_valid = 1'b1;
					if (frame_blk == expect_blk && frame_inv == ~expect_blk) begin
						r.tx_byte      = C_ACK;
						r.status       = ST_ACCEPT;
						r.block_number = frame_blk;
						expect_blk     = expect_blk + 8'd1;
						retry_cnt      = 4'd0;
						rx_phase       = PH_WAIT;
					end else if (frame_blk == prev && frame_inv == ~prev) begin
						r.tx_byte = C_ACK;
						retry_cnt = 4'd0;
						rx_phase  = PH_WAIT;
					end else begin
						r.tx_byte = C_CAN;
						r.status  = ST_SYNC;
						rx_phase  = PH_IDLE;
					end
				end
			end
		end
		endcase
		return r;
	endfunction

	task automatic add_event(op_t op, logic [7:0] b, logic [6:0] idx);
		line_event_t e;
		e.op         = op;
		e.rx_byte    = b;
		e.read_index = idx;
		e.pause      = pause_flag;
		e.reply      = step_receiver(op, b, idx);
		pause_flag   = 1'b0;
		pend_q.push_back(e);
		n_generated++;
	endtask

	task automatic add_byte(logic [7:0] b);
		add_event(OP_BYTE, b, 7'($urandom));
	endtask

	task automatic add_read();
		logic [6:0] idx;
		if (stored == '0)
			return;
		idx = 7'($urandom);
		while (!stored[idx])
			idx = 7'($urandom);
		add_event(OP_READ, 8'($urandom), idx);
	endtask

	task automatic add_ticks(int n);
		repeat (n)
			add_event(OP_TICK, 8'($urandom), 7'($urandom));
	endtask

	task automatic add_frame(logic [7:0] hdr, logic [7:0] blk, logic [7:0] inv, bit bad_sum,
		int count);
		logic [7:0] sum;
		logic [7:0] d;
		int i;
		sum = 8'h00;
		add_byte(hdr);
		add_byte(blk);
		add_byte(inv);
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 2)
				add_read();
			if ($urandom_range(0, 99) < frame_tick_pct)
				add_ticks(1);
			d = 8'($urandom);
			if ($urandom_range(0, 9) == 0)
				d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			sum = sum + d;
			add_byte(d);
		end
		if (count == BLOCK_BYTES_DEF)
			add_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
	endtask

	task automatic random_sequence();
		int k;
		int lim;
		logic [7:0] blk;
		logic [7:0] hdr;
		op_t op_pick;
		k = $urandom_range(0, 99);
		if (rx_phase == PH_IDLE && $urandom_range(0, 9) != 0)
			add_event(OP_START, 8'($urandom), 7'($urandom));
		if (k < 45) begin
			add_frame(C_SOH, expect_blk, ~expect_blk, 1'b0, BLOCK_BYTES_DEF);
		end else if (k < 53) begin
			blk = expect_blk - 8'd1;
			add_frame(C_SOH, blk, ~blk, 1'b0, BLOCK_BYTES_DEF);
		end else if (k < 60) begin
			add_frame(C_SOH, expect_blk, ~expect_blk, 1'b1, BLOCK_BYTES_DEF);
		end else if (k < 64) begin
			blk = 8'($urandom);
			hdr = $urandom_range(0, 1) ? ~blk : 8'($urandom);
			add_frame(C_SOH, blk, hdr, 1'b0, BLOCK_BYTES_DEF);
		end else if (k < 67) begin
			add_frame(C_SOH, expect_blk, ~expect_blk, 1'b0, $urandom_range(0, 40));
			lim = (cfg_now.block_timeout < 19) ? cfg_now.block_timeout + 1 : 20;
			add_ticks(lim);
		end else if (k < 71) begin
			hdr = 8'($urandom);
			if (hdr == C_SOH)
				hdr = 8'h02;
			add_frame(hdr, expect_blk, ~expect_blk, 1'b0, BLOCK_BYTES_DEF);
		end else if (k < 75) begin
			add_byte(C_EOT);
		end else if (k < 78) begin
			add_byte(C_CAN);
		end else if (k < 85) begin
			lim = (cfg_now.first_timeout < 19) ? cfg_now.first_timeout + 1 : 20;
			add_ticks($urandom_range(1, lim));
		end else if (k < 89) begin
			add_event(OP_START, 8'($urandom), 7'($urandom));
		end else if (k < 94) begin
			repeat ($urandom_range(1, 4))
				add_read();
		end else begin
			repeat ($urandom_range(1, 6)) begin
				op_pick = op_t'($urandom_range(0, 3));
				if (op_pick == OP_READ)
					add_read();
				else
					add_event(op_pick, 8'($urandom), 7'($urandom));
			end
		end
	endtask

	task automatic run_random(int n);
		int unsigned first;
		first = n_generated;
		while (n_generated - first < n)
			random_sequence();
	endtask

	task automatic set_config(logic [15:0] ft, logic [15:0] bt, logic [3:0] mr);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FIRST_TIMEOUT;
		cfg_data  <= ft;
		@(posedge clk);
		cfg_index <= REG_BLOCK_TIMEOUT;
		cfg_data  <= bt;
		@(posedge clk);
		cfg_index <= REG_MAX_RETRIES;
		cfg_data  <= CFG_W'(mr);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_now.first_timeout = ft;
		cfg_now.block_timeout = bt;
		cfg_now.max_retries   = mr;
		n_settings++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || reply_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid      <= 1'b0;
			item_bus.operation  <= OP_BYTE;
			item_bus.rx_byte    <= 8'h00;
			item_bus.read_index <= 7'h00;
		end else if (!(item_bus.valid && !item_bus.ready)) begin
			if (item_bus.valid) begin
				reply_q.push_back(pend_q[0].reply);
				pend_q.pop_front();
				n_events++;
			end
			if (pend_q.size() != 0 && !(pend_q[0].pause && reply_q.size() != 0) &&
				(hold_left != 0 || $urandom_range(0, 99) >= tx_idle_pct)) begin
				item_bus.valid      <= 1'b1;
				item_bus.operation  <= pend_q[0].op;
				item_bus.rx_byte    <= pend_q[0].rx_byte;
				item_bus.read_index <= pend_q[0].read_index;
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				got.tx_valid     = res_bus.tx_valid;
				got.tx_byte      = res_bus.tx_byte;
				got.status       = status_t'(res_bus.status);
				got.block_number = res_bus.block_number;
				got.read_data    = res_bus.read_data;
				if (reply_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word tx_valid=%0b tx_byte=%h status=%0d",
						$time, got.tx_valid, got.tx_byte, got.status);
				end else begin
					want = reply_q.pop_front();
					n_checked++;
					if (want.status == ST_ACCEPT)
						n_blocks++;
					if (want.status == ST_TIMEOUT)
						n_timeouts++;
					if (want.status == ST_SYNC)
						n_syncs++;
					if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
						got.status !== want.status || got.block_number !== want.block_number ||
						got.read_data !== want.read_data) begin
						errors++;
						if (errors <= 100) begin
							$write("%0t: mismatch expected tx_valid=%0b tx_byte=%h status=%0d",
								$time, want.tx_valid, want.tx_byte, want.status);
							$write(" block=%h read=%h", want.block_number, want.read_data);
							$write(", actual tx_valid=%0b tx_byte=%h status=%0d",
								got.tx_valid, got.tx_byte, got.status);
							$display(" block=%h read=%h", got.block_number, got.read_data);
						end
					end
				end
			end
			// one long hold-off while the sender keeps offering
			if (hold_left != 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (!hold_done && pend_q.size() > 30) begin
				hold_done = 1'b1;
				hold_left = 60;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		item_bus.valid      = 1'b0;
		item_bus.operation  = OP_BYTE;
		item_bus.rx_byte    = 8'h00;
		item_bus.read_index = 7'h00;
		res_bus.ready       = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_FIRST_TIMEOUT;
		cfg_data            = '0;
		arst_n              = 1'b0;
		cfg_now.first_timeout = FIRST_TIMEOUT_RST;
		cfg_now.block_timeout = BLOCK_TIMEOUT_RST;
		cfg_now.max_retries   = MAX_RETRIES_RST;
		rx_phase   = PH_IDLE;
		frame_pos  = 8'd0;
		tick_cnt   = '0;
		retry_cnt  = 4'd0;
		expect_blk = 8'd1;
		hdr_byte   = 8'h00;
		frame_blk  = 8'h00;
		frame_inv  = 8'h00;
		data_sum   = 8'h00;
		stored     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle events, cancel, end of transfer, restart
		add_byte(8'hFF);
		add_ticks(1);
		add_byte(8'h00);
		add_event(OP_START, 8'hFF, 7'h7F);
		add_byte(C_CAN);
		add_byte(8'h55);
		add_event(OP_START, 8'h00, 7'h00);
		add_byte(C_EOT);
		add_ticks(1);
		add_event(OP_START, 8'hAA, 7'h2A);
		add_event(OP_START, 8'h55, 7'h55);
		wait_drained();

		// timeouts in both phases until the retries run out
		set_config(16'd2, 16'd2, 4'd2);
		add_event(OP_START, 8'h00, 7'h00);
		add_ticks(2);
		add_byte(C_SOH);
		add_ticks(3);
		wait_drained();

		// zero timeouts and zero retries
		set_config(16'd0, 16'd0, 4'd0);
		add_event(OP_START, 8'h00, 7'h00);
		add_ticks(1);
		add_event(OP_START, 8'h00, 7'h00);
		add_byte(C_SOH);
		add_ticks(1);
		wait_drained();

		set_config(16'd3, 16'd5, 4'd3);
		frame_tick_pct = 1;
		run_random(110);
		wait_drained();

		tx_idle_pct = 74;
		rx_idle_pct = 23;
		set_config(16'hFFFF, 16'hFFFF, 4'd15);
		frame_tick_pct = 2;
		run_random(50);
		pause_flag = 1'b1;
		add_event(OP_START, 8'h00, 7'h00);
		add_ticks(2);
		wait_drained();

		set_config(16'($urandom_range(2, 12)), 16'($urandom_range(3, 40)),
			4'($urandom_range(2, 14)));
		frame_tick_pct = 1;
		run_random(110);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
			4'($urandom_range(1, 15)));
		run_random(110);
		wait_drained();

		repeat (8) @(posedge clk);
		if (reply_q.size() != 0) begin
			errors++;
			$display("%0t: %0d result words never arrived", $time, reply_q.size());
		end
		$display("checked %0d result words for %0d events under %0d register settings",
			n_checked, n_events, n_settings);
		$display("%0d blocks accepted, %0d retry timeouts, %0d sync errors, %0d mismatches",
			n_blocks, n_timeouts, n_syncs, errors);
		if (errors == 0)
			$display("[xmodem_block_receiver] OK");
		else
			$display("[xmodem_block_receiver] ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("[xmodem_block_receiver] ERROR");
		$finish;
	end

endmodule
